@@ src/assert_macros.svh @@
// Assertion macros used by the checker file cra_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRA_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("property violated");

// The consequent must hold in the cycle after the antecedent.
`define CRA_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("property violated");

`endif

@@ src/cra_pkg.sv @@
`timescale 1ns / 1ps

package cra_pkg;

  localparam int WORD_W     = 32;
  localparam int WORD_IDX_W = 5;
  localparam int CNT_W      = 6;
  localparam int REG_ID_W   = 8;
  localparam int HW_W       = 9;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int MAX_RUN    = 32;
  localparam int HW_MAX     = 511;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_REUSE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD     = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]     opcode;
    logic [CNT_W-1:0]    count;
    logic [REG_ID_W-1:0] start_register;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [REG_ID_W-1:0] granted_register;
    logic [HW_W-1:0]     high_water;
  } out_t;

  typedef struct packed {
    logic                  found;
    logic [WORD_IDX_W-1:0] idx;
  } match_t;

endpackage

@@ src/cra_run_match.sv @@
`timescale 1ns / 1ps

module cra_run_match import cra_pkg::*; (
  input  logic [2*WORD_W-1:0] free_i,
  input  logic [CNT_W-1:0]    count_i,
  output match_t              match_o
);

  logic [WORD_W-1:0] top_mask;
  logic [WORD_W-1:0] hit;

  assign top_mask = ~({WORD_W{1'b1}} >> count_i);

  // A hit at bit b means the run of count_i registers ending at bit b of the
  // upper word is entirely free.
  for (genvar b = 0; b < WORD_W; b++) begin : g_hit
    assign hit[b] = &(free_i[b+1 +: WORD_W] | ~top_mask);
  end

  always_comb begin
    match_o.found = |hit;
    match_o.idx   = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (hit[b]) begin
        match_o.idx = WORD_IDX_W'(b);
      end
    end
  end

endmodule

@@ src/cra_bitmap.sv @@
`timescale 1ns / 1ps

module cra_bitmap import cra_pkg::*; #(
  parameter int Words = 8,
  parameter int AddrW = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [AddrW-1:0]  addr_i,
  input  logic              we_i,
  input  logic [WORD_W-1:0] wdata_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] map_q [Words];

  assign rdata_o = map_q[addr_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Words; i++) begin
        map_q[i] <= '0;
      end
    end else if (we_i) begin
      map_q[addr_i] <= wdata_i;
    end
  end

endmodule

@@ src/contiguous_register_allocator.sv @@
// Steps from input transfer to result: allocate scans the bitmap words, one per cycle,
// then marks the run, with a second write when the run spans two words, or scans all
// REGISTER_COUNT/32 words when refused; free clears one or two words; reuse tests one bit.
// One request is in flight at a time, and the next input transfer can come at the
// edge that takes the result; a result not taken stalls the next one in its last state.
// Reset clears the bitmap and the high-water mark; the block is ready right after.
`timescale 1ns / 1ps

module contiguous_register_allocator import cra_pkg::*; #(
  parameter int REGISTER_COUNT = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int Words  = REGISTER_COUNT / WORD_W;
  localparam int WordAw = $clog2(Words);
  localparam int AbsW   = $clog2(REGISTER_COUNT + 1);
  localparam int CalcW  = (AbsW > HW_W) ? AbsW : HW_W;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SCAN    = 8'b0000_0010,
    S_MARK    = 8'b0000_0100,
    S_MARK_LO = 8'b0000_1000,
    S_FREE_LO = 8'b0001_0000,
    S_FREE_HI = 8'b0010_0000,
    S_REUSE   = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]      n_q, n_d;
  logic [REG_ID_W-1:0]   s_q, s_d;
  logic [WordAw-1:0]     w_q, w_d;
  logic [WORD_W-1:0]     prev_q, prev_d;
  logic [WORD_IDX_W-1:0] b_q, b_d;
  logic [2*WORD_W-1:0]   mask_q, mask_d;
  logic [CalcW-1:0]      hw_q, hw_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [REG_ID_W-1:0]   granted_q, granted_d;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q, out_d;

  logic              we;
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] wr_data;
  match_t            match;

  logic [CalcW-1:0]    s_ext;
  logic                cnt_ok;
  logic [CalcW-1:0]    end_abs;
  logic [CalcW-1:0]    start_abs;
  logic [6:0]          shamt;
  logic [2*WORD_W-1:0] run_mask;
  logic [2*WORD_W-1:0] free_mask;
  logic [HW_W-1:0]     hw_sat;

  cra_bitmap #(
    .Words (Words),
    .AddrW (WordAw)
  ) u_bitmap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .addr_i  (w_q),
    .we_i    (we),
    .wdata_i (wr_data),
    .rdata_o (rd_data)
  );

  cra_run_match u_match (
    .free_i  ({~rd_data, prev_q}),
    .count_i (n_q),
    .match_o (match)
  );

  assign s_ext     = CalcW'(in_data_i.start_register);
  assign cnt_ok    = (in_data_i.count != '0) && (in_data_i.count <= CNT_W'(MAX_RUN));
  assign end_abs   = CalcW'({w_q, b_q}) + CalcW'(1);
  assign start_abs = end_abs - CalcW'(n_q);
  assign shamt     = 7'd33 + 7'(b_q) - 7'(n_q);
  assign run_mask  = ((64'(1) << n_q) - 64'(1)) << shamt;
  assign free_mask = ((64'(1) << in_data_i.count) - 64'(1)) << s_ext[WORD_IDX_W-1:0];
  assign hw_sat    = (hw_q > CalcW'(HW_MAX)) ? HW_W'(HW_MAX) : hw_q[HW_W-1:0];

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    s_d         = s_q;
    w_d         = w_q;
    prev_d      = prev_q;
    b_d         = b_q;
    mask_d      = mask_q;
    hw_d        = hw_q;
    status_d    = status_q;
    granted_d   = granted_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    we          = 1'b0;
    wr_data     = rd_data;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          n_d       = in_data_i.count;
          s_d       = in_data_i.start_register;
          w_d       = '0;
          prev_d    = '0;
          granted_d = '0;
          status_d  = STATUS_BAD;
          state_d   = S_DONE;
          case (in_data_i.opcode)
            OP_ALLOC: begin
              if (cnt_ok) begin
                status_d = STATUS_REFUSED;
                state_d  = S_SCAN;
              end
            end
            OP_FREE: begin
              if (cnt_ok && (s_ext + CalcW'(in_data_i.count) <= CalcW'(REGISTER_COUNT))) begin
                w_d      = s_ext[WordAw+WORD_IDX_W-1:WORD_IDX_W];
                mask_d   = free_mask;
                status_d = STATUS_OK;
                state_d  = S_FREE_LO;
              end
            end
            OP_REUSE: begin
              if ((s_ext < CalcW'(REGISTER_COUNT)) && (s_ext < hw_q)) begin
                w_d     = s_ext[WordAw+WORD_IDX_W-1:WORD_IDX_W];
                state_d = S_REUSE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (match.found) begin
          b_d     = match.idx;
          state_d = S_MARK;
        end else if (w_q == WordAw'(Words - 1)) begin
          state_d = S_DONE;
        end else begin
          w_d    = w_q + WordAw'(1);
          prev_d = ~rd_data;
        end
      end
      S_MARK: begin
        we        = 1'b1;
        wr_data   = rd_data | run_mask[2*WORD_W-1:WORD_W];
        mask_d    = run_mask;
        status_d  = STATUS_OK;
        granted_d = start_abs[REG_ID_W-1:0];
        if (end_abs > hw_q) begin
          hw_d = end_abs;
        end
        if (run_mask[WORD_W-1:0] != '0) begin
          w_d     = w_q - WordAw'(1);
          state_d = S_MARK_LO;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MARK_LO: begin
        we      = 1'b1;
        wr_data = rd_data | mask_q[WORD_W-1:0];
        state_d = S_DONE;
      end
      S_FREE_LO: begin
        we      = 1'b1;
        wr_data = rd_data & ~mask_q[WORD_W-1:0];
        if ((rd_data & mask_q[WORD_W-1:0]) != mask_q[WORD_W-1:0]) begin
          status_d = STATUS_BAD;
        end
        if (mask_q[2*WORD_W-1:WORD_W] != '0) begin
          w_d     = w_q + WordAw'(1);
          state_d = S_FREE_HI;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FREE_HI: begin
        we      = 1'b1;
        wr_data = rd_data & ~mask_q[2*WORD_W-1:WORD_W];
        if ((rd_data & mask_q[2*WORD_W-1:WORD_W]) != mask_q[2*WORD_W-1:WORD_W]) begin
          status_d = STATUS_BAD;
        end
        state_d = S_DONE;
      end
      S_REUSE: begin
        if (rd_data[s_q[WORD_IDX_W-1:0]]) begin
          status_d = STATUS_REFUSED;
        end else begin
          we       = 1'b1;
          wr_data  = rd_data | (WORD_W'(1) << s_q[WORD_IDX_W-1:0]);
          status_d = STATUS_OK;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d            = 1'b1;
          out_d.status           = status_q;
          out_d.granted_register = granted_q;
          out_d.high_water       = hw_sat;
          state_d                = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hw_q        <= hw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    s_q       <= s_d;
    w_q       <= w_d;
    prev_q    <= prev_d;
    b_q       <= b_d;
    mask_q    <= mask_d;
    status_q  <= status_d;
    granted_q <= granted_d;
    out_q     <= out_d;
  end

endmodule

@@ src/cra_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cra_checker import cra_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  `CRA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `CRA_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `CRA_ASSERT_IMP(a_grant_zero, clk_i, rst_ni, out_valid_o && (out_data_o.status != STATUS_OK), out_data_o.granted_register == '0)
  `CRA_ASSERT_IMP(a_grant_below_mark, clk_i, rst_ni, out_valid_o && (out_data_o.status == STATUS_OK), HW_W'(out_data_o.granted_register) < out_data_o.high_water)

endmodule

bind contiguous_register_allocator cra_checker u_cra_checker (.*);

@@ tb/allocation_checker.sv @@
`timescale 1ns / 1ps

module allocation_checker import cra_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   mismatches_o,
  output int   pending_o,
  output int   results_o,
  output int   grants_o,
  output int   refusals_o,
  output int   misuse_o
);

  localparam int REG_TOTAL    = 256;
  localparam int MAP_WORDS    = REG_TOTAL / WORD_W;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    in_t  req;
    out_t reply;
  } expectation_t;

  logic [WORD_W-1:0] reg_map [MAP_WORDS];
  logic [HW_W-1:0]   hw_mark;
  expectation_t      expected_replies [$];
  expectation_t      head_entry;

  function automatic int used_in_run(int st, int n);
    int k;
    int used;
    used = 0;
    for (k = 0; k < n; k++) begin
      used += reg_map[(st + k) / WORD_W][(st + k) % WORD_W];
    end
    return used;
  endfunction

  function automatic void set_run(int st, int n, logic v);
    int k;
    for (k = 0; k < n; k++) begin
      reg_map[(st + k) / WORD_W][(st + k) % WORD_W] = v;
    end
  endfunction

  function automatic out_t predict_reply(in_t req);
    out_t reply;
    int   n;
    int   s;
    int   st;
    bit   placed;
    n = req.count;
    s = req.start_register;
    reply.status = STATUS_BAD;
    reply.granted_register = '0;
    placed = 1'b0;
    case (req.opcode)
      OP_ALLOC: begin
        if (n >= 1 && n <= MAX_RUN) begin
          reply.status = STATUS_REFUSED;
          for (st = 0; st + n <= REG_TOTAL && !placed; st++) begin
            if (used_in_run(st, n) == 0) begin
              set_run(st, n, 1'b1);
              if (st + n > hw_mark) hw_mark = HW_W'(st + n);
              reply.status = STATUS_OK;
              reply.granted_register = REG_ID_W'(st);
              placed = 1'b1;
            end
          end
        end
      end
      OP_FREE: begin
        if (n >= 1 && n <= MAX_RUN && s + n <= REG_TOTAL) begin
          // The whole run is cleared even when part of it was already free.
          reply.status = (used_in_run(s, n) == n) ? STATUS_OK : STATUS_BAD;
          set_run(s, n, 1'b0);
        end
      end
      OP_REUSE: begin
        if (s < hw_mark) begin
          if (reg_map[s / WORD_W][s % WORD_W]) begin
            reply.status = STATUS_REFUSED;
          end else begin
            set_run(s, 1, 1'b1);
            reply.status = STATUS_OK;
          end
        end
      end
      default: begin
      end
    endcase
    reply.high_water = (hw_mark > HW_MAX) ? HW_W'(HW_MAX) : hw_mark;
    return reply;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < MAP_WORDS; w++) reg_map[w] = '0;
      hw_mark = '0;
      expected_replies.delete();
      mismatches_o <= 0;
      pending_o <= 0;
      results_o <= 0;
      grants_o <= 0;
      refusals_o <= 0;
      misuse_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_replies.push_back('{in_data_i, predict_reply(in_data_i)});
      end
      if (out_valid_i && out_ready_i) begin
        results_o <= results_o + 1;
        if (expected_replies.size() == 0) begin
          if (mismatches_o < REPORT_LIMIT) begin
            $display("Unexpected result: status %0d granted %0d high_water %0d",
                     out_data_i.status, out_data_i.granted_register,
                     out_data_i.high_water);
          end
          mismatches_o <= mismatches_o + 1;
        end else begin
          head_entry = expected_replies.pop_front();
          if (head_entry.reply.status == STATUS_OK && head_entry.req.opcode == OP_ALLOC) begin
            grants_o <= grants_o + 1;
          end else if (head_entry.reply.status == STATUS_REFUSED) begin
            refusals_o <= refusals_o + 1;
          end else if (head_entry.reply.status == STATUS_BAD) begin
            misuse_o <= misuse_o + 1;
          end
          if (out_data_i.status !== head_entry.reply.status ||
              out_data_i.granted_register !== head_entry.reply.granted_register ||
              out_data_i.high_water !== head_entry.reply.high_water) begin
            if (mismatches_o < REPORT_LIMIT) begin
              $display("Mismatch for op %0d count %0d start %0d at %0t:",
                       head_entry.req.opcode, head_entry.req.count,
                       head_entry.req.start_register, $realtime);
              $display("  expected status %0d granted %0d high_water %0d",
                       head_entry.reply.status, head_entry.reply.granted_register,
                       head_entry.reply.high_water);
              $display("  actual   status %0d granted %0d high_water %0d",
                       out_data_i.status, out_data_i.granted_register,
                       out_data_i.high_water);
            end
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      pending_o <= expected_replies.size();
    end
  end

endmodule

@@ tb/tb_contiguous_register_allocator.sv @@
`timescale 1ns / 1ps

module tb_contiguous_register_allocator;
  import cra_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 7;
  localparam int REG_SPAN       = 256;
  localparam int TOTAL_ITEMS    = 1850;
  localparam int TAIL_ITEMS     = 150;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

  typedef struct packed {
    logic [REG_ID_W-1:0] first;
    logic [CNT_W-1:0]    len;
  } run_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  int mismatches;
  int pending_replies;
  int results_seen;
  int grants_seen;
  int refusals_seen;
  int misuse_seen;

  int   gap_pct         = 0;
  int   stall_pct       = 0;
  bit   long_hold_req   = 1'b0;
  int   requests_sent   = 0;
  int   directed_sent   = 0;
  int   quiet_cycles    = 0;
  int   high_water_seen = 0;
  in_t  issued_ops [$];
  run_t live_runs [$];
  in_t  answered_req;

  contiguous_register_allocator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  allocation_checker reply_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .mismatches_o (mismatches),
    .pending_o    (pending_replies),
    .results_o    (results_seen),
    .grants_o     (grants_seen),
    .refusals_o   (refusals_seen),
    .misuse_o     (misuse_seen)
  );

  always begin
    clk_i = 1'b0;
    #HALF_PERIOD;
    clk_i = 1'b1;
    #HALF_PERIOD;
  end

  function automatic in_t req_of(logic [OP_W-1:0] op, int n, int s);
    in_t req;
    req.opcode = op;
    req.count = CNT_W'(n);
    req.start_register = REG_ID_W'(s);
    return req;
  endfunction

  function automatic int run_length();
    int r;
    r = $urandom_range(9);
    if (r < 5) return $urandom_range(1, 4);
    if (r < 8) return $urandom_range(5, 16);
    return $urandom_range(17, MAX_RUN);
  endfunction

  function automatic int idle_level();
    int r;
    r = $urandom_range(2);
    return (r == 0) ? 0 : (r == 1) ? 10 : 35;
  endfunction

  function automatic in_t next_request(mix_e mix);
    in_t req;
    int  pick;
    int  alloc_pct;
    int  free_pct;
    int  idx;
    int  n;
    alloc_pct = (mix == MIX_FILL) ? 60 : (mix == MIX_DRAIN) ? 25 : 45;
    free_pct = (mix == MIX_FILL) ? 25 : (mix == MIX_DRAIN) ? 60 : 40;
    pick = $urandom_range(99);
    if (pick < alloc_pct) begin
      req = req_of(OP_ALLOC, run_length(), $urandom_range(REG_SPAN - 1));
    end else if (pick < alloc_pct + free_pct) begin
      if (live_runs.size() != 0) begin
        idx = $urandom_range(live_runs.size() - 1);
        req = req_of(OP_FREE, live_runs[idx].len, live_runs[idx].first);
        live_runs.delete(idx);
      end else begin
        n = run_length();
        req = req_of(OP_FREE, n, $urandom_range(REG_SPAN - n));
      end
    end else if (pick < 94) begin
      if (high_water_seen > 0 && $urandom_range(3) != 0) begin
        req = req_of(OP_REUSE, $urandom_range(63), $urandom_range(high_water_seen - 1));
      end else begin
        req = req_of(OP_REUSE, $urandom_range(63), $urandom_range(REG_SPAN - 1));
      end
    end else begin
      req = req_of(OP_W'($urandom_range(3)), $urandom_range(63),
                   $urandom_range(REG_SPAN - 1));
    end
    return req;
  endfunction

  task automatic issue(in_t req);
    in_valid_i <= 1'b1;
    in_data_i <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    issued_ops.push_back(req);
    requests_sent++;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_replies != 0);
  endtask

  task automatic clear_map();
    int w;
    wait_drained();
    live_runs.delete();
    for (w = 0; w < REG_SPAN / WORD_W; w++) issue(req_of(OP_FREE, WORD_W, w * WORD_W));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i && issued_ops.size() != 0) begin
      answered_req = issued_ops.pop_front();
      high_water_seen = out_data_o.high_water;
      if (answered_req.opcode == OP_ALLOC && out_data_o.status == STATUS_OK) begin
        live_runs.push_back('{out_data_o.granted_register, answered_req.count});
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles.", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    mix_e mix;
    int   phase;
    int   phase_len;
    int   remaining;
    bit   tail;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct = 10;
    stall_pct = 10;
    issue(req_of(OP_ALLOC, 0, 0));
    issue(req_of(OP_ALLOC, 63, 255));
    issue(req_of(OP_ALLOC, MAX_RUN + 1, 0));
    issue(req_of(OP_FREE, 0, 0));
    issue(req_of(OP_FREE, 10, 250));
    issue(req_of(OP_REUSE, 0, 0));
    issue(req_of(OP_UNKNOWN, 63, 255));
    issue(req_of(OP_ALLOC, MAX_RUN, 0));
    issue(req_of(OP_ALLOC, 1, 0));
    issue(req_of(OP_ALLOC, 31, 0));
    issue(req_of(OP_ALLOC, 20, 0));
    issue(req_of(OP_ALLOC, 20, 0));
    issue(req_of(OP_REUSE, 0, 5));
    issue(req_of(OP_FREE, 4, 0));
    issue(req_of(OP_REUSE, 0, 2));
    issue(req_of(OP_REUSE, 0, 200));
    issue(req_of(OP_FREE, 4, 0));
    issue(req_of(OP_FREE, 1, 255));
    issue(req_of(OP_FREE, MAX_RUN, 224));
    issue(req_of(OP_FREE, MAX_RUN, 225));
    issue(req_of(OP_ALLOC, MAX_RUN, 0));
    issue(req_of(OP_FREE, MAX_RUN, 32));
    issue(req_of(OP_REUSE, 63, 255));
    directed_sent = requests_sent;

    phase = 0;
    while (requests_sent < TOTAL_ITEMS) begin
      remaining = TOTAL_ITEMS - requests_sent;
      tail = (remaining <= TAIL_ITEMS);
      mix = mix_e'($urandom_range(2));
      if (tail) begin
        gap_pct = 0;
        stall_pct = 0;
        phase_len = remaining;
      end else begin
        gap_pct = idle_level();
        stall_pct = idle_level();
        phase_len = $urandom_range(60, 140);
        if (phase_len > remaining - TAIL_ITEMS) phase_len = remaining - TAIL_ITEMS;
        if (phase == 2) begin
          gap_pct = 0;
          long_hold_req = 1'b1;
        end
        if (phase == 5) wait_drained();
        if (phase % 4 == 3) clear_map();
      end
      repeat (phase_len) issue(next_request(mix));
      phase++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d requests (%0d directed) over %0d phases, %0d results checked.",
             requests_sent, directed_sent, phase, results_seen);
    $display("Outcomes: %0d grants, %0d refusals, %0d misuse results, high-water %0d.",
             grants_seen, refusals_seen, misuse_seen, high_water_seen);
    if (mismatches == 0 && pending_replies == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ contiguous_register_allocator.f @@
+incdir+src
src/cra_pkg.sv
src/cra_run_match.sv
src/cra_bitmap.sv
src/contiguous_register_allocator.sv
src/cra_checker.sv
tb/allocation_checker.sv
tb/tb_contiguous_register_allocator.sv
